FILE: design/dbc_pkg.sv
// Shared package of the density clustering block: field widths, payload structs,
// ring entry and cell control types, register indexes and sequencer states.
// No dependencies.
`default_nettype none

package dbc_pkg;

  localparam int unsigned CoordBits    = 20;
  localparam int unsigned EnergyBits   = 24;
  localparam int unsigned StoreEBits   = EnergyBits - 1;
  localparam int unsigned LabelBits    = 7;
  localparam int unsigned EpsBits      = 42;
  localparam int unsigned MinPtsBits   = 7;
  localparam int unsigned CfgDataBits  = 42;
  localparam int unsigned WSumBits     = 64;
  localparam int unsigned MaxPointsDef = 64;

  typedef enum logic [0:0] {
    CFG_EPS_SQUARED = 1'b0,
    CFG_MIN_POINTS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordBits-1:0]  pos_x;
    logic signed [CoordBits-1:0]  pos_y;
    logic signed [CoordBits-1:0]  pos_z;
    logic signed [EnergyBits-1:0] energy_diff;
    logic                         end_of_event;
  } hit_in_t;

  typedef struct packed {
    logic [6:0]                  cluster_number;
    logic [28:0]                 cluster_energy;
    logic signed [CoordBits-1:0] centroid_x;
    logic signed [CoordBits-1:0] centroid_y;
    logic signed [CoordBits-1:0] centroid_z;
    logic [6:0]                  member_count;
    logic                        has_cluster;
    logic                        hits_dropped;
    logic                        final_result;
  } result_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
  } hit_pos_t;

  typedef struct packed {
    logic                  valid;
    logic                  visited;
    logic                  queued;
    logic [LabelBits-1:0]  label;
    hit_pos_t              pos;
    logic [StoreEBits-1:0] energy;
  } entry_t;

  typedef struct packed {
    logic                 clear;
    logic                 load;
    logic                 shift;
    logic                 mark_visit;
    logic                 absorb_hit;
    logic [LabelBits-1:0] label;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_SEEK_OUTER,
    ST_COUNT,
    ST_DECIDE,
    ST_ABSORB,
    ST_SEEK_SEED,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } dbc_state_e;

endpackage

`default_nettype wire

FILE: design/dbc_cell.sv
// One cell of the hit ring: holds a stored hit with its label and flags.
// Depends on dbc_pkg.
`default_nettype none

module dbc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dbc_pkg::cell_ctrl_t ctrl_i,
  input  dbc_pkg::entry_t     load_i,
  input  dbc_pkg::entry_t     shift_i,
  output dbc_pkg::entry_t     entry_o
);

  dbc_pkg::entry_t entry_q, entry_d;

  // Clear or load, else a shift takes the neighbour's entry, updating the flags.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      entry_d.valid = 1'b0;
    end else if (ctrl_i.load) begin
      entry_d = load_i;
    end else if (ctrl_i.shift) begin
      entry_d = shift_i;
      if (ctrl_i.mark_visit) begin
        entry_d.visited = 1'b1;
        entry_d.queued  = 1'b0;
      end
      if (ctrl_i.absorb_hit) begin
        if (shift_i.label == '0) begin
          entry_d.label = ctrl_i.label;
        end
        if (!shift_i.visited && !shift_i.queued) begin
          entry_d.queued = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: design/dbc_dist.sv
// Two-stage squared distance unit comparing the ring head with the query hit.
// Depends on dbc_pkg.
`default_nettype none

module dbc_dist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           issue_i,
  input  dbc_pkg::hit_pos_t              head_i,
  input  dbc_pkg::hit_pos_t              query_i,
  input  logic [dbc_pkg::EpsBits-1:0]    eps_i,
  output logic                           hit_o,
  output logic                           near_o
);

  localparam int unsigned CB   = dbc_pkg::CoordBits;
  localparam int unsigned SqW  = 2 * CB;
  localparam int unsigned SumW = SqW + 2;
  localparam int unsigned CmpW = (SumW > dbc_pkg::EpsBits) ? SumW : dbc_pkg::EpsBits;

  function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    logic [CB:0]        m;
    d = {a[CB-1], a} - {b[CB-1], b};
    m = d[CB] ? (~d + 1'b1) : d;
    return m[CB-1:0];
  endfunction

  logic [CB-1:0]   ad_x_q, ad_y_q, ad_z_q;
  logic [SqW-1:0]  sq_x_q, sq_y_q, sq_z_q;
  logic            v1_q, v2_q;
  logic [SumW-1:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_x_q <= abs_diff(head_i.x, query_i.x);
    ad_y_q <= abs_diff(head_i.y, query_i.y);
    ad_z_q <= abs_diff(head_i.z, query_i.z);
    sq_x_q <= ad_x_q * ad_x_q;
    sq_y_q <= ad_y_q * ad_y_q;
    sq_z_q <= ad_z_q * ad_z_q;
  end

  assign sum    = SumW'(sq_x_q) + SumW'(sq_y_q) + SumW'(sq_z_q);
  assign hit_o  = v2_q;
  assign near_o = CmpW'(sum) <= CmpW'(eps_i);

endmodule

`default_nettype wire

FILE: design/dbc_div.sv
// Restoring divider, one quotient bit per cycle, keeping the low coordinate bits.
// Depends on dbc_pkg.
`default_nettype none

module dbc_div #(
  parameter int unsigned DivisorBits = 30
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [dbc_pkg::WSumBits-1:0]        dividend_i,
  input  logic [DivisorBits-1:0]              divisor_i,
  output logic                                done_o,
  output logic [dbc_pkg::CoordBits-1:0]       quotient_o
);

  localparam int unsigned DW       = dbc_pkg::WSumBits;
  localparam int unsigned CB       = dbc_pkg::CoordBits;
  localparam int unsigned StepBits = $clog2(DW + 1);

  logic [StepBits-1:0]    step_q;
  logic                   done_q;
  logic [DW-1:0]          dvd_q;
  logic [DivisorBits-1:0] rem_q;
  logic [CB-1:0]          quo_q;
  logic [DivisorBits:0]   shifted, trial;
  logic                   fits;

  assign shifted = {rem_q, dvd_q[DW-1]};
  assign fits    = shifted >= {1'b0, divisor_i};
  assign trial   = shifted - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == StepBits'(1));
      if (start_i) begin
        step_q <= StepBits'(DW);
      end else if (step_q != '0) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (step_q != '0) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= fits ? trial[DivisorBits-1:0] : shifted[DivisorBits-1:0];
      quo_q <= {quo_q[CB-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: design/density_clustering_centroid.sv
// Density clustering with energy-weighted centroids, built on a ring of hit cells.
// Hits are taken at one item per cycle while an event is collected. After the closing
// item each stored hit is sought in the ring and given a neighbour count sweep,
// and core hits one more absorb sweep; each cluster is then summed and its three
// centroid coordinates are divided one after another in the serial divider.
// Reset clears the ring flags, counters and output valid; registers return to defaults.
`default_nettype none

module density_clustering_centroid #(
  parameter int unsigned MAX_POINTS = dbc_pkg::MaxPointsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dbc_pkg::hit_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dbc_pkg::result_t                  out_data_o,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [dbc_pkg::CfgDataBits-1:0]   cfg_data_i
);

  // Widths that follow from the ring length and the package fields.
  localparam int unsigned IW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SCW = $clog2(MAX_POINTS + 2);
  localparam int unsigned ESW = dbc_pkg::StoreEBits + CW;
  localparam int unsigned PW  = dbc_pkg::CoordBits + dbc_pkg::EnergyBits;
  localparam int unsigned WW  = dbc_pkg::WSumBits;
  localparam int unsigned CB  = dbc_pkg::CoordBits;
  localparam int unsigned LB  = dbc_pkg::LabelBits;

  dbc_pkg::dbc_state_e st_q, st_d;

  dbc_pkg::entry_t     ring [MAX_POINTS];
  dbc_pkg::cell_ctrl_t ctrl [MAX_POINTS];
  dbc_pkg::entry_t     load_entry;
  dbc_pkg::entry_t     head;

  logic [dbc_pkg::EpsBits-1:0]    eps_q;
  logic [dbc_pkg::MinPtsBits-1:0] minp_q;

  logic [IW-1:0]  offset_q;
  logic [SCW-1:0] sc_q;
  logic [IW-1:0]  seek_cnt_q;
  logic [CW-1:0]  hit_count_q;
  logic           ovf_q;
  logic [CW-1:0]  op_q;
  logic           seed_phase_q;
  logic [CW-1:0]  cnt_q;
  logic [CW-1:0]  total_q;
  logic [CW-1:0]  cur_label_q;
  logic [CW-1:0]  c_q;
  logic [1:0]     div_k_q;
  logic           out_valid_q;
  dbc_pkg::result_t out_q, out_d;

  dbc_pkg::hit_pos_t query_q;

  // Report datapath: one product stage, then the accumulators.
  logic                  prod_v_q;
  logic signed [PW-1:0]  px_q, py_q, pz_q;
  logic [dbc_pkg::StoreEBits-1:0] pe_q;
  logic [ESW-1:0]        esum_q;
  logic [CW-1:0]         mcnt_q;
  logic [WW-1:0]         wx_q, wy_q, wz_q;
  logic [CB-1:0]         cx_q, cy_q, cz_q;

  // Handshake and decision terms.
  logic in_acc, e_pos, full, keep, out_free, final_res;
  logic outer_done, at_op, seed_hit, sweep_last, sum_last, core;
  logic dist_hit, dist_near, near_valid;

  // Sequencer outputs.
  logic rot, issue, mark, absorb_en, clear_ev, load_en, div_start;
  logic found_outer, found_seed, op_step, new_cluster;

  // Divider hookup.
  logic [WW-1:0] w_sel, w_mag;
  logic          w_neg, div_done;
  logic [CB-1:0] div_quo, cen_val;

  assign head = ring[0];

  assign in_acc   = in_valid_i && (st_q == dbc_pkg::ST_COLLECT);
  assign e_pos    = !in_data_i.energy_diff[dbc_pkg::EnergyBits-1] && (|in_data_i.energy_diff);
  assign full     = (hit_count_q == CW'(MAX_POINTS));
  assign keep     = e_pos && !full;
  assign out_free = !out_valid_q || !out_stall_i;

  assign outer_done = (op_q == hit_count_q);
  assign at_op      = (offset_q == op_q[IW-1:0]);
  assign seed_hit   = head.valid && head.queued && !head.visited;
  assign sweep_last = (sc_q == SCW'(MAX_POINTS + 1));
  assign sum_last   = (sc_q == SCW'(MAX_POINTS));
  assign core       = dbc_pkg::MinPtsBits'(cnt_q) >= minp_q;
  assign final_res  = (total_q == '0) || (c_q == total_q);
  assign near_valid = dist_hit && dist_near;

  always_comb begin
    load_entry         = '0;
    load_entry.valid   = 1'b1;
    load_entry.pos.x   = in_data_i.pos_x;
    load_entry.pos.y   = in_data_i.pos_y;
    load_entry.pos.z   = in_data_i.pos_z;
    load_entry.energy  = in_data_i.energy_diff[dbc_pkg::StoreEBits-1:0];
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      dbc_pkg::ST_COLLECT: begin
        if (in_acc && in_data_i.end_of_event) st_d = dbc_pkg::ST_SEEK_OUTER;
      end
      dbc_pkg::ST_SEEK_OUTER: begin
        if (outer_done) begin
          st_d = (total_q == '0) ? dbc_pkg::ST_EMIT : dbc_pkg::ST_SUM;
        end else if (at_op && !head.visited) begin
          st_d = dbc_pkg::ST_COUNT;
        end
      end
      dbc_pkg::ST_COUNT: begin
        if (sweep_last) st_d = dbc_pkg::ST_DECIDE;
      end
      dbc_pkg::ST_DECIDE: begin
        if (core) st_d = dbc_pkg::ST_ABSORB;
        else if (seed_phase_q) st_d = dbc_pkg::ST_SEEK_SEED;
        else st_d = dbc_pkg::ST_SEEK_OUTER;
      end
      dbc_pkg::ST_ABSORB: begin
        if (sweep_last) st_d = dbc_pkg::ST_SEEK_SEED;
      end
      dbc_pkg::ST_SEEK_SEED: begin
        if (seed_hit) st_d = dbc_pkg::ST_COUNT;
        else if (seek_cnt_q == IW'(MAX_POINTS - 1)) st_d = dbc_pkg::ST_SEEK_OUTER;
      end
      dbc_pkg::ST_SUM: begin
        if (sum_last) st_d = dbc_pkg::ST_DIV_GO;
      end
      dbc_pkg::ST_DIV_GO: begin
        st_d = dbc_pkg::ST_DIV_WAIT;
      end
      dbc_pkg::ST_DIV_WAIT: begin
        if (div_done) st_d = (div_k_q == 2'd2) ? dbc_pkg::ST_EMIT : dbc_pkg::ST_DIV_GO;
      end
      dbc_pkg::ST_EMIT: begin
        if (out_free) st_d = final_res ? dbc_pkg::ST_COLLECT : dbc_pkg::ST_SUM;
      end
      default: st_d = dbc_pkg::ST_COLLECT;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    rot         = 1'b0;
    found_outer = 1'b0;
    found_seed  = 1'b0;
    op_step     = 1'b0;
    new_cluster = 1'b0;
    case (st_q)
      dbc_pkg::ST_SEEK_OUTER: begin
        rot         = !outer_done && !at_op;
        found_outer = !outer_done && at_op && !head.visited;
        op_step     = !outer_done && at_op && head.visited;
      end
      dbc_pkg::ST_COUNT, dbc_pkg::ST_ABSORB, dbc_pkg::ST_SUM: begin
        rot = 1'b1;
      end
      dbc_pkg::ST_DECIDE: begin
        op_step     = !core && !seed_phase_q;
        new_cluster = core && !seed_phase_q;
      end
      dbc_pkg::ST_SEEK_SEED: begin
        rot        = !seed_hit;
        found_seed = seed_hit;
        op_step    = !seed_hit && (seek_cnt_q == IW'(MAX_POINTS - 1));
      end
      default: begin
        rot = 1'b0;
      end
    endcase
  end

  assign issue     = ((st_q == dbc_pkg::ST_COUNT) || (st_q == dbc_pkg::ST_ABSORB)) &&
                     (sc_q < SCW'(MAX_POINTS)) && head.valid;
  assign mark      = (st_q == dbc_pkg::ST_COUNT) && (sc_q == '0);
  assign absorb_en = (st_q == dbc_pkg::ST_ABSORB) && near_valid;
  assign clear_ev  = (st_q == dbc_pkg::ST_EMIT) && out_free && final_res;
  assign load_en   = in_acc && keep;
  assign div_start = (st_q == dbc_pkg::ST_DIV_GO);

  // The ring: cell k takes cell k+1 on each rotation. A distance result comes back
  // through the distance unit while the ring rotates, so the absorb update is
  // applied where its hit moves from the second-last cell into the third-last.
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ring
    assign ctrl[k].clear      = clear_ev;
    assign ctrl[k].load       = load_en && (hit_count_q == CW'(k));
    assign ctrl[k].shift      = rot;
    assign ctrl[k].mark_visit = mark && (k == MAX_POINTS - 1);
    assign ctrl[k].absorb_hit = absorb_en && (k == MAX_POINTS - 3);
    assign ctrl[k].label      = LB'(cur_label_q);

    dbc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .load_i  (load_entry),
      .shift_i (ring[(k + 1) % MAX_POINTS]),
      .entry_o (ring[k])
    );
  end

  dbc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .head_i  (head.pos),
    .query_i (query_q),
    .eps_i   (eps_q),
    .hit_o   (dist_hit),
    .near_o  (dist_near)
  );

  // Centroid division: weighted sum magnitude over the energy sum, sign put back.
  always_comb begin
    case (div_k_q)
      2'd0:    w_sel = wx_q;
      2'd1:    w_sel = wy_q;
      default: w_sel = wz_q;
    endcase
  end

  assign w_neg   = w_sel[WW-1];
  assign w_mag   = w_neg ? (~w_sel + 1'b1) : w_sel;
  assign cen_val = w_neg ? (~div_quo + 1'b1) : div_quo;

  dbc_div #(
    .DivisorBits (ESW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (w_mag),
    .divisor_i  (esum_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // The result item: an event without a cluster reports only the flags.
  always_comb begin
    out_d              = '0;
    out_d.hits_dropped = ovf_q;
    out_d.final_result = final_res;
    if (total_q != '0) begin
      out_d.cluster_number = 7'(c_q);
      out_d.cluster_energy = 29'(esum_q);
      out_d.centroid_x     = cx_q;
      out_d.centroid_y     = cy_q;
      out_d.centroid_z     = cz_q;
      out_d.member_count   = 7'(mcnt_q);
      out_d.has_cluster    = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= dbc_pkg::ST_COLLECT;
      eps_q        <= dbc_pkg::EpsBits'(65536);
      minp_q       <= dbc_pkg::MinPtsBits'(1);
      offset_q     <= '0;
      sc_q         <= '0;
      seek_cnt_q   <= '0;
      hit_count_q  <= '0;
      ovf_q        <= 1'b0;
      op_q         <= '0;
      seed_phase_q <= 1'b0;
      cnt_q        <= '0;
      total_q      <= '0;
      cur_label_q  <= '0;
      c_q          <= '0;
      div_k_q      <= '0;
      out_valid_q  <= 1'b0;
      prod_v_q     <= 1'b0;
    end else begin
      st_q <= st_d;

      if (cfg_we_i) begin
        if (cfg_idx_i == dbc_pkg::CFG_EPS_SQUARED) begin
          eps_q <= cfg_data_i[dbc_pkg::EpsBits-1:0];
        end else if (cfg_idx_i == dbc_pkg::CFG_MIN_POINTS) begin
          minp_q <= cfg_data_i[dbc_pkg::MinPtsBits-1:0];
        end
      end

      if (clear_ev) begin
        offset_q <= '0;
      end else if (rot) begin
        offset_q <= (offset_q == IW'(MAX_POINTS - 1)) ? '0 : offset_q + 1'b1;
      end

      if (st_d != st_q) begin
        sc_q <= '0;
      end else if (rot) begin
        sc_q <= sc_q + 1'b1;
      end

      if (st_q != dbc_pkg::ST_SEEK_SEED) begin
        seek_cnt_q <= '0;
      end else if (!seed_hit) begin
        seek_cnt_q <= seek_cnt_q + 1'b1;
      end

      if (clear_ev) begin
        hit_count_q <= '0;
        ovf_q       <= 1'b0;
        total_q     <= '0;
      end else begin
        if (load_en) hit_count_q <= hit_count_q + 1'b1;
        if (in_acc && e_pos && full) ovf_q <= 1'b1;
        if (new_cluster) total_q <= total_q + 1'b1;
      end

      if (in_acc && in_data_i.end_of_event) begin
        op_q <= '0;
      end else if (op_step) begin
        op_q <= op_q + 1'b1;
      end

      if (found_outer) seed_phase_q <= 1'b0;
      else if (found_seed) seed_phase_q <= 1'b1;

      if (st_q != dbc_pkg::ST_COUNT) begin
        cnt_q <= '0;
      end else if (near_valid) begin
        cnt_q <= cnt_q + 1'b1;
      end

      if (new_cluster) cur_label_q <= total_q + 1'b1;

      if ((st_q == dbc_pkg::ST_SEEK_OUTER) && outer_done) begin
        c_q <= CW'(1);
      end else if ((st_q == dbc_pkg::ST_EMIT) && out_free && !final_res) begin
        c_q <= c_q + 1'b1;
      end

      if (st_q == dbc_pkg::ST_SUM) begin
        div_k_q <= '0;
      end else if ((st_q == dbc_pkg::ST_DIV_WAIT) && div_done) begin
        div_k_q <= div_k_q + 1'b1;
      end

      if ((st_q == dbc_pkg::ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      prod_v_q <= (st_q == dbc_pkg::ST_SUM) && (sc_q < SCW'(MAX_POINTS)) && head.valid &&
                  (head.label == LB'(c_q));
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (found_outer || found_seed) begin
      query_q <= head.pos;
    end

    px_q <= head.pos.x * $signed({1'b0, head.energy});
    py_q <= head.pos.y * $signed({1'b0, head.energy});
    pz_q <= head.pos.z * $signed({1'b0, head.energy});
    pe_q <= head.energy;

    if ((st_d == dbc_pkg::ST_SUM) && (st_q != dbc_pkg::ST_SUM)) begin
      esum_q <= '0;
      mcnt_q <= '0;
      wx_q   <= '0;
      wy_q   <= '0;
      wz_q   <= '0;
    end else if (prod_v_q) begin
      esum_q <= esum_q + ESW'(pe_q);
      mcnt_q <= mcnt_q + 1'b1;
      wx_q   <= wx_q + WW'(px_q);
      wy_q   <= wy_q + WW'(py_q);
      wz_q   <= wz_q + WW'(pz_q);
    end

    if ((st_q == dbc_pkg::ST_DIV_WAIT) && div_done) begin
      case (div_k_q)
        2'd0:    cx_q <= cen_val;
        2'd1:    cy_q <= cen_val;
        default: cz_q <= cen_val;
      endcase
    end

    if ((st_q == dbc_pkg::ST_EMIT) && out_free) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (st_q != dbc_pkg::ST_COLLECT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: bench/dbc_result_checker.sv
// Checker for the density clustering block: watches the hit, result and register
// channels, predicts the cluster results of each closed event and compares them.
// Depends on dbc_pkg for the payload structs and register indexes.
`default_nettype none

module dbc_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  dbc_pkg::hit_in_t                in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  dbc_pkg::result_t                out_data_i,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [dbc_pkg::CfgDataBits-1:0] cfg_data_i,
  output int                              errors_o,
  output int                              outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity = int'(dbc_pkg::MaxPointsDef);
  localparam int Unlabelled = 255;
  localparam int Noise = 0;

  logic [dbc_pkg::EpsBits-1:0]    eps_sq;
  logic [dbc_pkg::MinPtsBits-1:0] min_pts;
  longint                hx[Capacity], hy[Capacity], hz[Capacity], he[Capacity];
  int                    label[Capacity];
  bit                    visited[Capacity], queued[Capacity];
  int                    n_hits;
  bit                    overflow;
  dbc_pkg::result_t      cluster_results[$];

  function automatic bit near(int i, int j);
    longint unsigned dx, dy, dz;
    dx = hx[i] - hx[j];
    dy = hy[i] - hy[j];
    dz = hz[i] - hz[j];
    return (dx * dx + dy * dy + dz * dz) <= longint'(eps_sq);
  endfunction

  function automatic int density(int p);
    int n;
    n = 0;
    for (int j = 0; j < n_hits; j++) if (near(p, j)) n++;
    return n;
  endfunction

  // Labels unlabelled and noise neighbours of core hit p; queues unvisited ones.
  function automatic void grow(int p, int c, ref int seeds[$]);
    for (int j = 0; j < n_hits; j++) begin
      if (near(p, j)) begin
        if (label[j] == Unlabelled || label[j] == Noise) label[j] = c;
        if (!visited[j] && !queued[j]) begin
          queued[j] = 1;
          seeds = {seeds, j};
        end
      end
    end
  endfunction

  function automatic void close_event();
    int               total, q, cnt;
    int               seeds[$];
    longint           esum, wx, wy, wz;
    dbc_pkg::result_t r;
    total = 0;
    for (int i = 0; i < n_hits; i++) begin
      if (!visited[i]) begin
        visited[i] = 1;
        if (density(i) < min_pts) begin
          if (label[i] == Unlabelled) label[i] = Noise;
        end else begin
          total++;
          label[i] = total;
          seeds.delete();
          grow(i, total, seeds);
          while (seeds.size() > 0) begin
            q = seeds.pop_front();
            if (!visited[q]) begin
              visited[q] = 1;
              if (density(q) >= min_pts) grow(q, total, seeds);
            end
          end
          for (int k = 0; k < Capacity; k++) queued[k] = 0;
        end
      end
    end
    if (total == 0) begin
      r = '0;
      r.hits_dropped = overflow;
      r.final_result = 1'b1;
      cluster_results = {cluster_results, r};
    end
    for (int c = 1; c <= total; c++) begin
      cnt = 0; esum = 0; wx = 0; wy = 0; wz = 0;
      for (int i = 0; i < n_hits; i++) begin
        if (label[i] == c) begin
          cnt++;
          esum += he[i];
          wx += hx[i] * he[i];
          wy += hy[i] * he[i];
          wz += hz[i] * he[i];
        end
      end
      r.cluster_number = c[6:0];
      r.cluster_energy = esum[28:0];
      r.centroid_x     = dbc_pkg::CoordBits'(wx / esum);
      r.centroid_y     = dbc_pkg::CoordBits'(wy / esum);
      r.centroid_z     = dbc_pkg::CoordBits'(wz / esum);
      r.member_count   = cnt[6:0];
      r.has_cluster    = 1'b1;
      r.hits_dropped   = overflow;
      r.final_result   = (c == total);
      cluster_results = {cluster_results, r};
    end
    n_hits = 0;
    overflow = 0;
  endfunction

  function automatic int field_diff(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, e, a);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dbc_pkg::result_t exp_r, act_r;
    int               bad;
    if (!rst_ni) begin
      eps_sq <= 65536;
      min_pts <= 1;
      n_hits = 0;
      overflow = 0;
      errors_o <= 0;
      outstanding_o <= 0;
      cluster_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == dbc_pkg::CFG_EPS_SQUARED) eps_sq <= cfg_data_i[dbc_pkg::EpsBits-1:0];
        else min_pts <= cfg_data_i[dbc_pkg::MinPtsBits-1:0];
      end
      bad = 0;
      if (out_valid_i && !out_stall_i) begin
        act_r = out_data_i;
        if (cluster_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, act_r);
          bad++;
        end else begin
          exp_r = cluster_results.pop_front();
          bad += field_diff("cluster_number", exp_r.cluster_number, act_r.cluster_number);
          bad += field_diff("cluster_energy", exp_r.cluster_energy, act_r.cluster_energy);
          bad += field_diff("centroid_x", exp_r.centroid_x, act_r.centroid_x);
          bad += field_diff("centroid_y", exp_r.centroid_y, act_r.centroid_y);
          bad += field_diff("centroid_z", exp_r.centroid_z, act_r.centroid_z);
          bad += field_diff("member_count", exp_r.member_count, act_r.member_count);
          bad += field_diff("has_cluster", exp_r.has_cluster, act_r.has_cluster);
          bad += field_diff("hits_dropped", exp_r.hits_dropped, act_r.hits_dropped);
          bad += field_diff("final_result", exp_r.final_result, act_r.final_result);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if ($signed(in_data_i.energy_diff) > 0) begin
          if (n_hits < Capacity) begin
            hx[n_hits] = in_data_i.pos_x;
            hy[n_hits] = in_data_i.pos_y;
            hz[n_hits] = in_data_i.pos_z;
            he[n_hits] = in_data_i.energy_diff;
            label[n_hits] = Unlabelled;
            visited[n_hits] = 0;
            queued[n_hits] = 0;
            n_hits++;
          end else begin
            overflow = 1;
          end
        end
        if (in_data_i.end_of_event) close_event();
      end
      if (bad != 0) errors_o <= errors_o + 1;
      outstanding_o <= cluster_results.size();
    end
  end

endmodule

`default_nettype wire

FILE: bench/density_clustering_centroid_test.sv
// Top of the density clustering testbench: clock, reset, register settings and hit
// stimulus, with random idling on both channels, and the final verdict.
// Depends on dbc_pkg, the block under test and dbc_result_checker.
`default_nettype none

module density_clustering_centroid_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i, in_stall_o;
  dbc_pkg::hit_in_t                in_data_i;
  logic                            out_valid_o, out_stall_i;
  dbc_pkg::result_t                out_data_o;
  logic                            cfg_we_i;
  logic [0:0]                      cfg_idx_i;
  logic [dbc_pkg::CfgDataBits-1:0] cfg_data_i;
  int                              errors, outstanding;
  bit                              calm;

  always #6 clk_i = ~clk_i;

  density_clustering_centroid DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  dbc_result_checker checker_u (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .outstanding_o(outstanding)
  );

  // The receiving side stalls in random bursts until the calm part of the run.
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Offers one item and holds it until it is accepted. Valid is left high, so that
  // a following item goes out back to back unless an idle burst is chosen.
  task automatic send_hit(dbc_pkg::hit_in_t h);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic dbc_pkg::hit_in_t make_hit(int x, int y, int z, int e, bit last);
    dbc_pkg::hit_in_t h;
    h.pos_x = x[dbc_pkg::CoordBits-1:0];
    h.pos_y = y[dbc_pkg::CoordBits-1:0];
    h.pos_z = z[dbc_pkg::CoordBits-1:0];
    h.energy_diff = e[dbc_pkg::EnergyBits-1:0];
    h.end_of_event = last;
    return h;
  endfunction

  // Waits for every result of the closed event and then for the block to settle,
  // so that a register write only ever meets an idle block.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(dbc_pkg::cfg_idx_e idx, logic [dbc_pkg::CfgDataBits-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One event of clustered hits around a few random centres, with some noise hits
  // spread over the whole range and a few hits of no energy.
  task automatic random_event(int n_hits, int spread);
    int cx[3], cy[3], cz[3];
    int k, e;
    for (int c = 0; c < 3; c++) begin
      cx[c] = $signed($urandom_range(0, 20'hFFFFF) - 524288);
      cy[c] = $signed($urandom_range(0, 20'hFFFFF) - 524288);
      cz[c] = $signed($urandom_range(0, 20'hFFFFF) - 524288);
    end
    for (int i = 0; i < n_hits; i++) begin
      k = $urandom_range(0, 2);
      e = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(0, 8388608))
                                      : int'($urandom_range(1, 8388607));
      if ($urandom_range(0, 4) == 0)
        send_hit(make_hit($urandom, $urandom, $urandom, e, i == n_hits - 1));
      else
        send_hit(make_hit(cx[k] + $urandom_range(0, 2 * spread) - spread,
                          cy[k] + $urandom_range(0, 2 * spread) - spread,
                          cz[k] + $urandom_range(0, 2 * spread) - spread,
                          e, i == n_hits - 1));
    end
    drain();
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= dbc_pkg::CFG_EPS_SQUARED;
    cfg_data_i <= '0;
    calm = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extreme positions and energies at the reset settings.
    send_hit(make_hit(-524288, -524288, -524288, 8388607, 0));
    send_hit(make_hit(-524288, -524288, -524288, 1, 0));
    send_hit(make_hit(524287, 524287, 524287, 8388607, 0));
    send_hit(make_hit(0, 0, 0, 0, 0));
    send_hit(make_hit(100, 100, 100, -8388608, 0));
    send_hit(make_hit(524287, 524287, 524286, 5, 1));
    drain();
    // An event whose only hit has no energy gives the no-cluster result.
    send_hit(make_hit(0, 0, 0, -1, 1));
    drain();
    // A dropped closing hit still closes the event; four hits close together form
    // one cluster and the far hit is left as noise.
    write_reg(dbc_pkg::CFG_MIN_POINTS, 3);
    send_hit(make_hit(0, 0, 0, 16, 0));
    send_hit(make_hit(200, 0, 0, 32, 0));
    send_hit(make_hit(400, 0, 0, 48, 0));
    send_hit(make_hit(200, 100, 0, 64, 0));
    send_hit(make_hit(-300, -300, -300, 7, 0));
    send_hit(make_hit(9, 9, 9, 0, 1));
    drain();
    // Minimum points of zero makes every hit core; a zero radius joins only
    // coincident hits.
    write_reg(dbc_pkg::CFG_MIN_POINTS, 0);
    write_reg(dbc_pkg::CFG_EPS_SQUARED, 0);
    send_hit(make_hit(-5, 7, 9, 100, 0));
    send_hit(make_hit(-5, 7, 9, 3, 0));
    send_hit(make_hit(6, 7, 9, 11, 1));
    drain();
    // The largest radius makes the two far corners near; at 127 points none is core.
    write_reg(dbc_pkg::CFG_EPS_SQUARED, 42'h3FF_FFFF_FFFF);
    write_reg(dbc_pkg::CFG_MIN_POINTS, 127);
    send_hit(make_hit(-524288, -524288, -524288, 3, 0));
    send_hit(make_hit(524287, 524287, 524287, 5, 1));
    drain();

    // Random events over a settings cycle, one with more hits than the store holds.
    // Only the last few events run without idling.
    for (int ev = 0; ev < 12; ev++) begin
      calm = (ev >= 9);
      case (ev % 6)
        0: begin
          write_reg(dbc_pkg::CFG_EPS_SQUARED, 65536);
          write_reg(dbc_pkg::CFG_MIN_POINTS, 1);
        end
        1: write_reg(dbc_pkg::CFG_MIN_POINTS,
                     dbc_pkg::CfgDataBits'($urandom_range(2, 4)));
        2: write_reg(dbc_pkg::CFG_EPS_SQUARED,
                     dbc_pkg::CfgDataBits'({$urandom, $urandom}));
        3: begin
          write_reg(dbc_pkg::CFG_EPS_SQUARED,
                    dbc_pkg::CfgDataBits'($urandom_range(10000, 400000)));
          write_reg(dbc_pkg::CFG_MIN_POINTS, 64);
        end
        4: write_reg(dbc_pkg::CFG_MIN_POINTS,
                     dbc_pkg::CfgDataBits'($urandom_range(0, 127)));
        default: write_reg(dbc_pkg::CFG_EPS_SQUARED, 0);
      endcase
      if (ev == 7) random_event($urandom_range(65, 68), 300);
      else random_event($urandom_range(1, 6), $urandom_range(50, 600));
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("density_clustering_centroid_test passed");
    end else begin
      $display("density_clustering_centroid_test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("density_clustering_centroid_test failed");
    $finish;
  end

endmodule

`default_nettype wire
